// ===== hdl/rrqs_pkg.sv =====
// ----------------------------------------------------------------------------
// rrqs_pkg: shared types and constants for the round-robin quota scheduler
// Status codes, controller states and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rrqs_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int ID_W          = 16;
  localparam int TIME_W        = 16;
  localparam int STATUS_W      = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_LISTED = 2'd0,
    ST_ACCEPT = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RESP,
    S_RUN
  } state_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } op_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_wr;    // append the input process at the tail
    logic    run_start;  // clear the round counters, fetch entry 0
    logic    advance;    // emit current entry, compact it, fetch next
    logic    rsp_valid;  // load a single response into the output register
    status_t rsp_code;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic full;
    logic empty;
    logic last_entry;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== hdl/round_robin_quota_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// round_robin_quota_scheduler_core: round-robin scheduler with per-process quota
// Usage:
//   Input channel (in_valid/in_stall) takes one beat per item: op=0 appends a
//   process (proc_id, burst_time, time_quota), op=1 runs one round.
//   Output channel (out_valid/out_stall) returns listed_id, status, last.
//   A load gives one beat: accepted, or refused when the ring is full.
//   A run lists every present id in ring order (last set on the final one),
//   serving each process its quota; finished processes drop out in the same
//   pass. A run on an empty ring gives one empty-status beat.
//   An accepted item moves the controller to S_RESP or S_RUN, which loads
//   result beats into the output register. A run lists one entry per cycle
//   through the single read port of the process store while the output is
//   free. in_stall stays high until the item's last beat is in the output
//   register.
//   A stalled receiver freezes the round; the output beat holds until taken.
//   Reset empties the ring; store contents need no clearing.
// ----------------------------------------------------------------------------
module round_robin_quota_scheduler_core #(
  parameter int MAX_PROCS = rrqs_pkg::MAX_PROCS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          op,
  input  logic [rrqs_pkg::ID_W-1:0]     proc_id,
  input  logic [rrqs_pkg::TIME_W-1:0]   burst_time,
  input  logic [rrqs_pkg::TIME_W-1:0]   time_quota,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrqs_pkg::ID_W-1:0]     listed_id,
  output logic [rrqs_pkg::STATUS_W-1:0] status,
  output logic                          last
);
  import rrqs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rrqs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .op       (op),
    .stat     (stat),
    .cmd      (cmd)
  );

  rrqs_datapath #(
    .MAX_PROCS (MAX_PROCS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .proc_id    (proc_id),
    .burst_time (burst_time),
    .time_quota (time_quota),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .listed_id  (listed_id),
    .status     (status),
    .last       (last)
  );

endmodule

// ===== hdl/rrqs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrqs_ctrl: scheduler controller
// Decodes accepted items and sequences the listing/compaction pass of a round.
// ----------------------------------------------------------------------------
module rrqs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  rrqs_pkg::dp_stat_t stat,
  output rrqs_pkg::dp_cmd_t  cmd
);
  import rrqs_pkg::*;

  state_t  state, state_next;
  status_t code, code_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      code  <= ST_EMPTY;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

  always_comb begin
    state_next    = state;
    code_next     = code;
    in_stall      = 1'b1;
    cmd.load_wr   = 1'b0;
    cmd.run_start = 1'b0;
    cmd.advance   = 1'b0;
    cmd.rsp_valid = 1'b0;
    cmd.rsp_code  = code;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (op_t'(op) == OP_LOAD) begin
            cmd.load_wr = !stat.full;
            code_next   = stat.full ? ST_FULL : ST_ACCEPT;
            state_next  = S_RESP;
          end else if (stat.empty) begin
            code_next  = ST_EMPTY;
            state_next = S_RESP;
          end else begin
            cmd.run_start = 1'b1;
            state_next    = S_RUN;
          end
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.rsp_valid = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_RUN: begin
        if (stat.out_free) begin
          cmd.advance = 1'b1;
          if (stat.last_entry) state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== hdl/rrqs_datapath.sv =====
// ----------------------------------------------------------------------------
// rrqs_datapath: process store, round counters and output register
// One memory holds id/remaining/quota per entry. A round reads entry r and
// writes survivors back at w (w <= r), so the ring compacts in place.
// ----------------------------------------------------------------------------
module rrqs_datapath #(
  parameter int MAX_PROCS = rrqs_pkg::MAX_PROCS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rrqs_pkg::dp_cmd_t             cmd,
  output rrqs_pkg::dp_stat_t            stat,
  input  logic [rrqs_pkg::ID_W-1:0]     proc_id,
  input  logic [rrqs_pkg::TIME_W-1:0]   burst_time,
  input  logic [rrqs_pkg::TIME_W-1:0]   time_quota,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrqs_pkg::ID_W-1:0]     listed_id,
  output logic [rrqs_pkg::STATUS_W-1:0] status,
  output logic                          last
);
  import rrqs_pkg::*;

  localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] rem;
    logic [TIME_W-1:0] quota;
  } entry_t;

  entry_t mem [MAX_PROCS];
  entry_t rd_data;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  entry_t        wr_data;
  logic          survive;
  logic [CW-1:0] rd_ptr_inc;
  logic [TIME_W-1:0] quota_fix;

  assign rd_ptr_inc      = rd_ptr + CW'(1);
  assign stat.full       = (count == CW'(MAX_PROCS));
  assign stat.empty      = (count == '0);
  assign stat.last_entry = (rd_ptr_inc == count);
  assign stat.out_free   = !out_valid || !out_stall;

  assign survive   = rd_data.rem > rd_data.quota;
  assign quota_fix = (time_quota == '0) ? TIME_W'(1) : time_quota;

  always_comb begin
    rd_ptr_next = rd_ptr;
    wr_ptr_next = wr_ptr;
    count_next  = count;
    wr_en       = 1'b0;
    wr_addr     = count[AW-1:0];
    wr_data     = '{id: proc_id, rem: burst_time, quota: quota_fix};
    rd_addr     = rd_ptr[AW-1:0];
    if (cmd.load_wr) begin
      wr_en      = 1'b1;
      count_next = count + CW'(1);
    end
    if (cmd.run_start) begin
      rd_ptr_next = '0;
      wr_ptr_next = '0;
      rd_addr     = '0;
    end
    if (cmd.advance) begin
      rd_ptr_next = rd_ptr_inc;
      rd_addr     = rd_ptr_inc[AW-1:0];
      wr_addr     = wr_ptr[AW-1:0];
      wr_data     = '{id: rd_data.id, rem: rd_data.rem - rd_data.quota,
                      quota: rd_data.quota};
      wr_en       = survive;
      if (survive) wr_ptr_next = wr_ptr + CW'(1);
      if (stat.last_entry) count_next = wr_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rd_ptr <= '0;
      wr_ptr <= '0;
    end else begin
      count  <= count_next;
      rd_ptr <= rd_ptr_next;
      wr_ptr <= wr_ptr_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.advance || cmd.rsp_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance) begin
      listed_id <= rd_data.id;
      status    <= ST_LISTED;
      last      <= stat.last_entry;
    end else if (cmd.rsp_valid) begin
      listed_id <= '0;
      status    <= cmd.rsp_code;
      last      <= 1'b1;
    end
  end

endmodule

// ===== hdl/rrqs_checker.sv =====
// ----------------------------------------------------------------------------
// rrqs_checker: port-level checks for the scheduler core
// Watches the top-level ports and flags ordering and framing slips.
// ----------------------------------------------------------------------------
module rrqs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [rrqs_pkg::ID_W-1:0]     listed_id,
  input logic [rrqs_pkg::STATUS_W-1:0] status,
  input logic                          last
);
  import rrqs_pkg::*;

  // a held output beat does not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(listed_id) && $stable(status)
      && $stable(last))
    else $error("output beat changed while stalled");

  // one item at a time: after an accepted beat the input stalls
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while previous item in flight");

  // single-beat responses always close the item
  a_resp_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_LISTED) |-> last && (listed_id == '0))
    else $error("response beat without last or with nonzero id");

  // input opens only once the item's final beat is out
  a_open_after_last: assert property (@(posedge clk) disable iff (rst)
    $fell(in_stall) |-> out_valid && last)
    else $error("input reopened before final beat");

endmodule

bind round_robin_quota_scheduler_core rrqs_checker u_rrqs_checker (.*);

// ===== tb/sv/round_robin_quota_scheduler_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_quota_scheduler_core_tb: self-checking bench for the scheduler
// A directed table, then random load/run traffic. Every accepted item goes
// through a local scheduler model; it or the table queues the expected beats.
// Output beats are checked in order against that queue. Both channels idle at
// random. One long receiver hold-off and one full drain pause are included.
// ----------------------------------------------------------------------------
module round_robin_quota_scheduler_core_tb;
  import rrqs_pkg::*;

  localparam int MAX_PROCS   = MAX_PROCS_DEF;
  localparam int RAND_ITEMS  = 336;
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int PAUSE_AT    = 240;
  localparam int TAIL_CYCLES = 2 * MAX_PROCS + 8;
  localparam int LIMIT       = 1000000;
  localparam int MAX_PRINTS  = 30;

  typedef struct {
    op_t         op;
    logic [15:0] pid;
    logic [15:0] burst;
    logic [15:0] quota;
    bit          typed;
    status_t     want;
  } row_t;

  typedef struct {
    logic [15:0] pid;
    status_t     st;
    logic        fin;
  } beat_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        op;
  logic [15:0] proc_id;
  logic [15:0] burst_time;
  logic [15:0] time_quota;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] listed_id;
  logic [1:0]  status;
  logic        last;

  // scheduler model state
  logic [15:0] ring_id    [MAX_PROCS];
  logic [15:0] ring_left  [MAX_PROCS];
  logic [15:0] ring_quota [MAX_PROCS];
  int          ring_count;

  beat_t       due_beats[$];
  row_t        plan[$];
  int          items_sent;
  int          errors;
  int          cycles;
  bit          tight;

  round_robin_quota_scheduler_core #(.MAX_PROCS(MAX_PROCS)) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .proc_id    (proc_id),
    .burst_time (burst_time),
    .time_quota (time_quota),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .listed_id  (listed_id),
    .status     (status),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    if (errors < MAX_PRINTS)
      $display("mismatch @%0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // append one expected beat at the back of the queue
  task automatic queue_beat(input beat_t b);
    due_beats = {due_beats, b};
  endtask

  // One item through the scheduler model; listed beats are queued when keep is set.
  task automatic schedule_item(input op_t iop, input logic [15:0] pid, input logic [15:0] burst,
                               input logic [15:0] quota, input bit keep);
    int r;
    int n;
    int w;
    beat_t b;
    if (iop == OP_LOAD) begin
      if (ring_count >= MAX_PROCS) begin
        b = '{16'h0000, ST_FULL, 1'b1};
      end else begin
        ring_id[ring_count]    = pid;
        ring_left[ring_count]  = burst;
        ring_quota[ring_count] = (quota == 16'h0000) ? 16'h0001 : quota;
        ring_count++;
        b = '{16'h0000, ST_ACCEPT, 1'b1};
      end
      if (keep) queue_beat(b);
    end else if (ring_count == 0) begin
      b = '{16'h0000, ST_EMPTY, 1'b1};
      if (keep) queue_beat(b);
    end else begin
      n = ring_count;
      for (r = 0; r < n; r++) begin
        b = '{ring_id[r], ST_LISTED, (r == n - 1)};
        if (keep) queue_beat(b);
      end
      // serve quotas, compact survivors in order
      w = 0;
      for (r = 0; r < n; r++) begin
        if (ring_left[r] > ring_quota[r]) begin
          ring_id[w]    = ring_id[r];
          ring_left[w]  = ring_left[r] - ring_quota[r];
          ring_quota[w] = ring_quota[r];
          w++;
        end
      end
      ring_count = w;
    end
  endtask

  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tight || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_row(input op_t iop, input logic [15:0] pid, input logic [15:0] burst,
                         input logic [15:0] quota, input bit typed, input status_t want);
    row_t it;
    it = '{iop, pid, burst, quota, typed, want};
    plan = {plan, it};
  endtask

  task automatic send_item(input row_t it);
    int gap;
    beat_t b;
    gap = pick_gap();
    if (items_sent == PAUSE_AT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (due_beats.size() != 0);
    end else if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op         <= it.op;
    proc_id    <= it.pid;
    burst_time <= it.burst;
    time_quota <= it.quota;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    schedule_item(it.op, it.pid, it.burst, it.quota, !it.typed);
    if (it.typed) begin
      b = '{16'h0000, it.want, 1'b1};
      queue_beat(b);
    end
    items_sent++;
  endtask

  // sender
  initial begin : sender
    int i;
    int k;
    int sel;
    int load_pct;
    row_t it;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    op         <= OP_LOAD;
    proc_id    <= 16'h0000;
    burst_time <= 16'h0000;
    time_quota <= 16'h0000;
    ring_count = 0;
    items_sent = 0;
    tight      = 1'b0;
    load_pct   = 60;

    add_row(OP_RUN,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, ST_EMPTY);
    add_row(OP_LOAD, 16'hFFFF, 16'h0000, 16'h0000, 1'b1, ST_ACCEPT);  // zero burst, zero quota
    add_row(OP_LOAD, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, ST_ACCEPT);  // done in one round
    add_row(OP_LOAD, 16'h1234, 16'd5,    16'h0000, 1'b1, ST_ACCEPT);
    add_row(OP_LOAD, 16'hA5A5, 16'hFFFF, 16'h0001, 1'b1, ST_ACCEPT);
    add_row(OP_RUN,  16'h0000, 16'h0000, 16'h0000, 1'b0, ST_LISTED);
    add_row(OP_RUN,  16'h0000, 16'h0000, 16'h0000, 1'b0, ST_LISTED);
    // two left; fill the ring
    for (k = 0; k < MAX_PROCS - 2; k++)
      add_row(OP_LOAD, 16'h0100 + k[15:0], k[15:0], 16'(k % 3), 1'b1, ST_ACCEPT);
    add_row(OP_LOAD, 16'h5A5A, 16'h0001, 16'h0001, 1'b1, ST_FULL);
    add_row(OP_RUN,  16'h0000, 16'h0000, 16'h0000, 1'b0, ST_LISTED);
    add_row(OP_RUN,  16'h0000, 16'h0000, 16'h0000, 1'b0, ST_LISTED);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[j]) send_item(plan[j]);

    for (i = 0; i < RAND_ITEMS; i++) begin
      if (i % 30 == 0) begin
        sel = $urandom_range(0, 2);
        load_pct = (sel == 0) ? 35 : (sel == 1) ? 60 : 90;
        tight = ($urandom_range(0, 3) == 0);
      end
      it.typed = 1'b0;
      it.want  = ST_LISTED;
      it.op    = ($urandom_range(0, 99) < load_pct) ? OP_LOAD : OP_RUN;
      it.pid   = 16'($urandom_range(0, 65535));
      sel = $urandom_range(0, 99);
      if (sel < 10)      it.burst = 16'h0000;
      else if (sel < 18) it.burst = 16'($urandom_range(0, 65535));
      else               it.burst = 16'($urandom_range(1, 10));
      sel = $urandom_range(0, 99);
      if (sel < 10)      it.quota = 16'h0000;
      else if (sel < 20) it.quota = 16'hFFFF;
      else if (sel < 30) it.quota = 16'($urandom_range(0, 65535));
      else               it.quota = 16'($urandom_range(1, 4));
      // keep long jobs from pinning the ring forever
      if (it.burst > 16'd100 && it.quota < (it.burst >> 2))
        it.quota = 16'($urandom_range(int'(it.burst >> 2), 65535));
      send_item(it);
    end
    in_valid <= 1'b0;

    while (due_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // receiver stall pattern, with one long hold-off
  initial begin : receiver
    int run_left;
    int hold_left;
    int pct;
    bit stalling;
    bit hold_done;
    out_stall <= 1'b0;
    run_left  = 0;
    hold_left = 0;
    pct       = 30;
    stalling  = 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (run_left == 0) begin
        if ($urandom_range(0, 9) == 0) pct = $urandom_range(0, 2) * 30;
        stalling = ($urandom_range(0, 99) < pct);
        run_left = pick_len();
      end
      run_left--;
      if (hold_left > 0) hold_left--;
      out_stall <= stalling || (hold_left > 0);
    end
  end

  // output beat checker
  always @(posedge clk) begin
    beat_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_beats.size() == 0) begin
        report("unexpected beat, listed_id", listed_id, 16'h0000);
      end else begin
        want = due_beats.pop_front();
        if (listed_id !== want.pid) report("listed_id", listed_id, want.pid);
        if (status !== want.st)     report("status", 16'(status), 16'(want.st));
        if (last !== want.fin)      report("last", 16'(last), 16'(want.fin));
      end
    end
  end

endmodule
